// ===== hw/rtl/lfr_pkg.sv =====
// Package for the link frame receiver with reply.
// Holds the byte codes, error bit positions, position codes and the reply request type.
// No dependencies.
package lfr_pkg;

  localparam logic [7:0] FlagByte = 8'h7E;
  localparam logic [7:0] SetCtrl  = 8'h03;
  localparam logic [7:0] UaCtrl   = 8'h07;
  localparam logic [7:0] ICtrl0   = 8'h00;
  localparam logic [7:0] ICtrl1   = 8'h40;
  localparam logic [7:0] Rr0Ctrl  = 8'h05;
  localparam logic [7:0] Rr1Ctrl  = 8'h85;

  localparam logic [7:0] ExpectedAddressReset = 8'h03;
  localparam logic [7:0] ReplyAddressReset    = 8'h01;

  localparam int unsigned MaxFieldBytesDefault = 256;
  localparam int unsigned CfgIndexWidth        = 8;

  localparam logic [CfgIndexWidth-1:0] CfgExpectedAddress = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] CfgReplyAddress    = CfgIndexWidth'(1);

  localparam int unsigned NumErr  = 6;
  localparam int unsigned ErrFlag = 0;
  localparam int unsigned ErrAddr = 1;
  localparam int unsigned ErrCtrl = 2;
  localparam int unsigned ErrHdr  = 3;
  localparam int unsigned ErrData = 4;
  localparam int unsigned ErrLen  = 5;

  // Reply queue depth; a power of two so the pointers wrap by themselves.
  localparam int unsigned QueueDepth = 2;

  // Reply byte positions.
  localparam logic [2:0] RpFlagOpen  = 3'd0;
  localparam logic [2:0] RpAddr      = 3'd1;
  localparam logic [2:0] RpCtrl      = 3'd2;
  localparam logic [2:0] RpCheck     = 3'd3;
  localparam logic [2:0] RpFlagClose = 3'd4;

  typedef enum logic [2:0] {
    PosOpen     = 3'd0,
    PosAddr     = 3'd1,
    PosCtrl     = 3'd2,
    PosHdr      = 3'd3,
    PosSetClose = 3'd4,
    PosData     = 3'd5
  } pos_e;

  typedef struct packed {
    logic              kind;
    logic              seq;
    logic [NumErr-1:0] err;
  } reply_req_t;

endpackage

// ===== hw/rtl/lfr_front.sv =====
// Front part of the link frame receiver: parses received bytes by position.
// Pushes one reply request per finished frame. Depends on lfr_pkg.
module lfr_front #(
  parameter int unsigned MAX_FIELD_BYTES = lfr_pkg::MaxFieldBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [7:0]         expected_address_i,
  output logic               push_o,
  output lfr_pkg::reply_req_t req_o
);

  localparam int unsigned LenW = $clog2(MAX_FIELD_BYTES + 2);
  localparam logic [LenW-1:0] LenMax = LenW'(MAX_FIELD_BYTES);

  lfr_pkg::pos_e pos_q, pos_d;
  logic                      info_q, info_d;
  logic [7:0]                hxor_q, hxor_d;
  logic                      fnum_q, fnum_d;
  logic [7:0]                dxor_q, dxor_d;
  logic [LenW-1:0]           len_q, len_d;
  logic [lfr_pkg::NumErr-1:0] err_q, err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= lfr_pkg::PosOpen;
      info_q <= 1'b0;
      hxor_q <= '0;
      fnum_q <= 1'b0;
      dxor_q <= '0;
      len_q  <= '0;
      err_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      info_q <= info_d;
      hxor_q <= hxor_d;
      fnum_q <= fnum_d;
      dxor_q <= dxor_d;
      len_q  <= len_d;
      err_q  <= err_d;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    info_d = info_q;
    hxor_d = hxor_q;
    fnum_d = fnum_q;
    dxor_d = dxor_q;
    len_d  = len_q;
    err_d  = err_q;
    push_o = 1'b0;
    req_o  = '{kind: 1'b0, seq: 1'b0, err: err_q};
    if (accept_i) begin
      unique case (pos_q)
        lfr_pkg::PosAddr: begin
          if (rx_byte_i != expected_address_i) err_d[lfr_pkg::ErrAddr] = 1'b1;
          hxor_d = rx_byte_i;
          pos_d  = lfr_pkg::PosCtrl;
        end
        lfr_pkg::PosCtrl: begin
          if (info_q) begin
            if (rx_byte_i != lfr_pkg::ICtrl0 && rx_byte_i != lfr_pkg::ICtrl1) begin
              err_d[lfr_pkg::ErrCtrl] = 1'b1;
            end
            fnum_d = (rx_byte_i != lfr_pkg::ICtrl0);
          end else if (rx_byte_i != lfr_pkg::SetCtrl) begin
            err_d[lfr_pkg::ErrCtrl] = 1'b1;
          end
          hxor_d = hxor_q ^ rx_byte_i;
          pos_d  = lfr_pkg::PosHdr;
        end
        lfr_pkg::PosHdr: begin
          if (rx_byte_i != hxor_q) err_d[lfr_pkg::ErrHdr] = 1'b1;
          pos_d = info_q ? lfr_pkg::PosData : lfr_pkg::PosSetClose;
        end
        lfr_pkg::PosSetClose: begin
          if (rx_byte_i != lfr_pkg::FlagByte) err_d[lfr_pkg::ErrFlag] = 1'b1;
          pos_d  = lfr_pkg::PosOpen;
          info_d = 1'b1;
          push_o = 1'b1;
          req_o  = '{kind: 1'b0, seq: 1'b0, err: err_d};
        end
        lfr_pkg::PosData: begin
          if (rx_byte_i == lfr_pkg::FlagByte) begin
            if (len_q == '0 || len_q > LenMax) err_d[lfr_pkg::ErrLen] = 1'b1;
            if (dxor_q != 8'h00) err_d[lfr_pkg::ErrData] = 1'b1;
            pos_d  = lfr_pkg::PosOpen;
            info_d = 1'b0;
            push_o = 1'b1;
            req_o  = '{kind: 1'b1, seq: fnum_q, err: err_d};
          end else begin
            dxor_d = dxor_q ^ rx_byte_i;
            if (len_q <= LenMax) len_d = len_q + LenW'(1);
          end
        end
        default: begin
          // Opening flag; a wrong byte still opens the frame.
          err_d                   = '0;
          err_d[lfr_pkg::ErrFlag] = (rx_byte_i != lfr_pkg::FlagByte);
          hxor_d = '0;
          dxor_d = '0;
          len_d  = '0;
          fnum_d = 1'b0;
          pos_d  = lfr_pkg::PosAddr;
        end
      endcase
    end
  end

  // A frame end always returns the parser to the opening flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> pos_q == lfr_pkg::PosOpen)
    else $error("parser did not return to opening flag after frame end");

  // The data length never runs past its saturation value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenMax + LenW'(1))
    else $error("data length beyond saturation");

endmodule

// ===== hw/rtl/lfr_queue.sv =====
// Short queue of reply requests between the frame parser and the reply sender.
// Depends on lfr_pkg.
module lfr_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lfr_pkg::reply_req_t push_req_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                nonempty_o,
  output lfr_pkg::reply_req_t head_o
);

  localparam int unsigned PtrW = $clog2(lfr_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(lfr_pkg::QueueDepth + 1);

  lfr_pkg::reply_req_t       entry_q [lfr_pkg::QueueDepth];
  logic [PtrW-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]           cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(lfr_pkg::QueueDepth));
  assign nonempty_o = (cnt_q != '0);
  assign head_o     = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_req_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("reply request pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !nonempty_o |-> !pop_i)
    else $error("reply request popped from an empty queue");

endmodule

// ===== hw/rtl/lfr_back.sv =====
// Back part of the link frame receiver: sends the five reply bytes for each request.
// Depends on lfr_pkg.
module lfr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  lfr_pkg::reply_req_t req_i,
  input  logic [7:0]          reply_address_i,
  input  logic                out_stall_i,
  output logic                req_pop_o,
  output logic                out_valid_o,
  output logic [7:0]          reply_byte_o,
  output logic                last_of_reply_o
);

  logic [2:0] idx_q, idx_d;
  logic [7:0] ctrl;
  logic       take;

  assign ctrl = req_i.kind ? (req_i.seq ? lfr_pkg::Rr0Ctrl : lfr_pkg::Rr1Ctrl)
                           : lfr_pkg::UaCtrl;

  assign out_valid_o     = req_valid_i;
  assign take            = req_valid_i && !out_stall_i;
  assign last_of_reply_o = (idx_q == lfr_pkg::RpFlagClose);
  assign req_pop_o       = take && last_of_reply_o;

  always_comb begin
    case (idx_q)
      lfr_pkg::RpAddr:  reply_byte_o = reply_address_i;
      lfr_pkg::RpCtrl:  reply_byte_o = ctrl;
      lfr_pkg::RpCheck: reply_byte_o = reply_address_i ^ ctrl;
      default:          reply_byte_o = lfr_pkg::FlagByte;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last_of_reply_o ? lfr_pkg::RpFlagOpen : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= lfr_pkg::RpFlagOpen;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Without a pending request the sender rests at the first reply byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_valid_i |-> idx_q == lfr_pkg::RpFlagOpen)
    else $error("reply byte counter moved with no request pending");

endmodule

// ===== hw/rtl/link_frame_receiver_with_reply.sv =====
// Top level of the link frame receiver with reply.
// Instantiates lfr_front, lfr_queue and lfr_back; depends on lfr_pkg.
//
//   Channel   Direction  Handshake                Payload
//   input     in         in_valid_i / in_stall_o  rx_byte_i
//   output    out        out_valid_o / out_stall_i reply_byte_o, last_of_reply_o,
//                                                 frame_kind_o, sequence_bit_o, error flags
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One received byte is taken per cycle while in_stall_o is low.
// The reply sender sends five reply bytes per finished frame, one per unstalled cycle.
// A two-entry request queue sits between parser and sender, so input stalls only
// while both entries are held; since a frame has at least five bytes, the sender
// keeps up at full rate when unstalled. Reset (rst_ni low, asynchronous) returns
// the parser to await a SET frame and restores expected_address 3, reply_address 1.
module link_frame_receiver_with_reply #(
  parameter int unsigned MAX_FIELD_BYTES = lfr_pkg::MaxFieldBytesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Received bytes.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        rx_byte_i,
  // Reply bytes.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        reply_byte_o,
  output logic                              last_of_reply_o,
  output logic                              frame_kind_o,
  output logic                              sequence_bit_o,
  output logic                              flag_error_o,
  output logic                              address_error_o,
  output logic                              control_error_o,
  output logic                              header_check_error_o,
  output logic                              data_check_error_o,
  output logic                              length_error_o,
  // Configuration writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lfr_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);

  logic [7:0]          expected_address_q;
  logic [7:0]          reply_address_q;
  logic                in_accept;
  logic                push;
  lfr_pkg::reply_req_t push_req;
  logic                q_full;
  logic                q_nonempty;
  lfr_pkg::reply_req_t head;
  logic                pop;

  // Configuration registers. Writes must be made only while idle, which the block
  // does not enforce; the parser and sender read them directly. Unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_address_q <= lfr_pkg::ExpectedAddressReset;
      reply_address_q    <= lfr_pkg::ReplyAddressReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == lfr_pkg::CfgExpectedAddress) begin
        expected_address_q <= cfg_data_i;
      end else if (cfg_index_i == lfr_pkg::CfgReplyAddress) begin
        reply_address_q <= cfg_data_i;
      end
    end
  end

  // The parser can push a request on a frame's closing byte, so it holds off while the
  // queue has no free entry.
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !in_stall_o;

  lfr_front #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (in_accept),
    .rx_byte_i          (rx_byte_i),
    .expected_address_i (expected_address_q),
    .push_o             (push),
    .req_o              (push_req)
  );

  lfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .full_o     (q_full),
    .nonempty_o (q_nonempty),
    .head_o     (head)
  );

  lfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (q_nonempty),
    .req_i           (head),
    .reply_address_i (reply_address_q),
    .out_stall_i     (out_stall_i),
    .req_pop_o       (pop),
    .out_valid_o     (out_valid_o),
    .reply_byte_o    (reply_byte_o),
    .last_of_reply_o (last_of_reply_o)
  );

  // Per-frame fields are held in the queue entry for all five reply bytes.
  assign frame_kind_o         = head.kind;
  assign sequence_bit_o       = head.seq;
  assign flag_error_o         = head.err[lfr_pkg::ErrFlag];
  assign address_error_o      = head.err[lfr_pkg::ErrAddr];
  assign control_error_o      = head.err[lfr_pkg::ErrCtrl];
  assign header_check_error_o = head.err[lfr_pkg::ErrHdr];
  assign data_check_error_o   = head.err[lfr_pkg::ErrData];
  assign length_error_o       = head.err[lfr_pkg::ErrLen];

endmodule
